@@ rtl/ufdc_pkg.sv @@
// ----------------------------------------------------------------------------
// ufdc_pkg
// Shared constants, result codes and controller/datapath signal groups for
// the serial frame deframer with checksum.
// ----------------------------------------------------------------------------
package ufdc_pkg;

    localparam int unsigned MAX_FRAME_BYTES_DEF = 64;

    // Width of the configuration register index, wide enough to see writes
    // beyond the register list.
    localparam int unsigned CFG_IDX_W = 8;

    // Width used for length and count comparisons.
    localparam int unsigned CMP_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_START_CODE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PARTNER_ACK = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_GOOD_REPLY  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_BAD_REPLY   = CFG_IDX_W'(3);

    localparam logic [7:0] START_CODE_RST  = 8'd46;
    localparam logic [7:0] PARTNER_ACK_RST = 8'hFF;
    localparam logic [7:0] GOOD_REPLY_RST  = 8'hFF;
    localparam logic [7:0] BAD_REPLY_RST   = 8'hF0;

    localparam logic [7:0] SUM_INVERT = 8'hFF;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_ERR  = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;

    typedef struct packed {
        logic capture;
        logic start_frame;
        logic store;
        logic add_sum;
        logic load_len;
        logic rd_clear;
        logic rd_issue;
        logic out_byte;
        logic out_err;
        logic out_ack;
    } ufdc_cmd_t;

    typedef struct packed {
        logic is_start;
        logic is_ack;
        logic oversize;
        logic rx_zero;
        logic payload_done;
        logic sum_match;
        logic rd_last;
        logic out_free;
    } ufdc_stat_t;

endpackage

@@ rtl/ufdc_rx_if.sv @@
// ----------------------------------------------------------------------------
// ufdc_rx_if
// Received byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ufdc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/ufdc_res_if.sv @@
// ----------------------------------------------------------------------------
// ufdc_res_if
// Result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ufdc_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] frame_data;
    logic       last;
    logic       ack_seen;
    logic       reply_valid;
    logic [7:0] reply_byte;

    modport source (output valid, output kind, output frame_data, output last,
                    output ack_seen, output reply_valid, output reply_byte,
                    input ready);
    modport sink (input valid, input kind, input frame_data, input last,
                  input ack_seen, input reply_valid, input reply_byte,
                  output ready);
endinterface

@@ rtl/ufdc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// ufdc_cfg_if
// Configuration register write channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ufdc_cfg_if import ufdc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/ufdc_dpath.sv @@
// ----------------------------------------------------------------------------
// ufdc_dpath
// Deframer datapath: configuration registers, frame store, byte count,
// running checksum, replay read port and the result output register.
// ----------------------------------------------------------------------------
module ufdc_dpath import ufdc_pkg::*; #(
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ufdc_cmd_t            cmd,
    output ufdc_stat_t           stat,
    input  logic [7:0]           rx_byte,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 res_ready,
    output logic                 res_valid,
    output logic [1:0]           kind,
    output logic [7:0]           frame_data,
    output logic                 last,
    output logic                 ack_seen,
    output logic                 reply_valid,
    output logic [7:0]           reply_byte
);

    localparam int unsigned AW = $clog2(MAX_FRAME_BYTES);
    localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);

    logic [7:0]    start_code_reg;
    logic [7:0]    partner_ack_reg;
    logic [7:0]    good_reply_reg;
    logic [7:0]    bad_reply_reg;

    logic [7:0]    rx_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [7:0]    len_reg;
    logic [7:0]    len_next;
    logic [7:0]    sum_reg;
    logic [7:0]    sum_next;
    logic [AW-1:0] rd_idx_reg;
    logic [AW-1:0] rd_idx_next;
    logic [7:0]    rd_data_reg;

    logic [7:0]    frame_mem [MAX_FRAME_BYTES];
    logic [AW-1:0] wr_addr;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic          out_load;
    logic [1:0]    kind_reg;
    logic [7:0]    data_reg;
    logic          last_reg;
    logic          ack_reg;
    logic          rv_reg;
    logic [7:0]    rb_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg  <= START_CODE_RST;
            partner_ack_reg <= PARTNER_ACK_RST;
            good_reply_reg  <= GOOD_REPLY_RST;
            bad_reply_reg   <= BAD_REPLY_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_START_CODE:  start_code_reg  <= cfg_data;
                REG_PARTNER_ACK: partner_ack_reg <= cfg_data;
                REG_GOOD_REPLY:  good_reply_reg  <= cfg_data;
                REG_BAD_REPLY:   bad_reply_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Frame bookkeeping.
    always_comb
    begin
        count_next  = count_reg;
        len_next    = len_reg;
        sum_next    = sum_reg;
        rd_idx_next = rd_idx_reg;
        if (cmd.start_frame)
        begin
            count_next = CW'(1);
            len_next   = 8'd0;
            sum_next   = 8'd0;
        end
        else
        begin
            if (cmd.store)
            begin
                count_next = count_reg + CW'(1);
            end
            if (cmd.add_sum)
            begin
                sum_next = sum_reg + rx_reg;
            end
            if (cmd.load_len)
            begin
                len_next = rx_reg;
            end
        end
        if (cmd.rd_clear)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.out_byte)
        begin
            rd_idx_next = rd_idx_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            len_reg    <= 8'd0;
            sum_reg    <= 8'd0;
            rd_idx_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            len_reg    <= len_next;
            sum_reg    <= sum_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rx_reg <= rx_byte;
        end
    end

    // The count never reaches the store depth while a byte is being stored,
    // because oversize frames are dropped on the length byte.
    assign wr_addr = cmd.start_frame ? '0 : count_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            frame_mem[wr_addr] <= rx_reg;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= frame_mem[rd_idx_reg];
        end
    end

    // Result output register.
    assign out_load = cmd.out_byte | cmd.out_err | cmd.out_ack;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ack_reg <= stat.is_ack;
            if (cmd.out_byte)
            begin
                kind_reg <= KIND_BYTE;
                data_reg <= rd_data_reg;
                last_reg <= stat.rd_last;
                rv_reg   <= stat.rd_last;
                rb_reg   <= stat.rd_last ? good_reply_reg : 8'd0;
            end
            else if (cmd.out_err)
            begin
                kind_reg <= KIND_ERR;
                data_reg <= 8'd0;
                last_reg <= 1'b1;
                rv_reg   <= 1'b1;
                rb_reg   <= bad_reply_reg;
            end
            else
            begin
                kind_reg <= KIND_ACK;
                data_reg <= 8'd0;
                last_reg <= 1'b1;
                rv_reg   <= 1'b0;
                rb_reg   <= 8'd0;
            end
        end
    end

    // Status towards the controller.
    assign stat.is_start     = (rx_reg == start_code_reg);
    assign stat.is_ack       = (rx_reg == partner_ack_reg);
    assign stat.oversize     = (CMP_W'(rx_reg) + CMP_W'(4)) > CMP_W'(MAX_FRAME_BYTES);
    assign stat.rx_zero      = (rx_reg == 8'd0);
    assign stat.payload_done = (CMP_W'(count_reg) + CMP_W'(1)) >= (CMP_W'(len_reg) + CMP_W'(3));
    assign stat.sum_match    = ((sum_reg ^ SUM_INVERT) == rx_reg);
    assign stat.rd_last      = ((CW'(rd_idx_reg) + CW'(1)) == count_reg);
    assign stat.out_free     = !out_valid_reg || res_ready;

    assign res_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign frame_data  = data_reg;
    assign last        = last_reg;
    assign ack_seen    = ack_reg;
    assign reply_valid = rv_reg;
    assign reply_byte  = rb_reg;

endmodule

@@ rtl/ufdc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ufdc_ctrl
// Deframer controller: the frame parsing phase and the sequencer that takes
// one byte, evaluates it and issues its results.
// ----------------------------------------------------------------------------
module ufdc_ctrl import ufdc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ufdc_stat_t stat,
    output ufdc_cmd_t  cmd
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_TYPE    = 3'd1;
    localparam logic [2:0] PH_LEN     = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CHECK   = 3'd4;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_ERR  = 3'd2;
    localparam logic [2:0] ST_ACK  = 3'd3;
    localparam logic [2:0] ST_RD   = 3'd4;
    localparam logic [2:0] ST_WR   = 3'd5;

    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       replay;
    logic       bad_sum;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        phase_next = phase_reg;
        state_next = state_reg;
        replay     = 1'b0;
        bad_sum    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                case (phase_reg)
                    PH_HUNT:
                    begin
                        if (stat.is_start)
                        begin
                            cmd.start_frame = 1'b1;
                            cmd.store       = 1'b1;
                            phase_next      = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        cmd.store   = 1'b1;
                        cmd.add_sum = 1'b1;
                        phase_next  = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        cmd.load_len = 1'b1;
                        if (stat.oversize)
                        begin
                            phase_next = PH_HUNT;
                        end
                        else
                        begin
                            cmd.store   = 1'b1;
                            cmd.add_sum = 1'b1;
                            phase_next  = stat.rx_zero ? PH_CHECK : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        cmd.store   = 1'b1;
                        cmd.add_sum = 1'b1;
                        if (stat.payload_done)
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                    default:
                    begin
                        // Checksum byte: it is stored so that the replay
                        // includes it.
                        cmd.store  = 1'b1;
                        phase_next = PH_HUNT;
                        replay     = stat.sum_match;
                        bad_sum    = !stat.sum_match;
                    end
                endcase
                if (replay)
                begin
                    cmd.rd_clear = 1'b1;
                    state_next   = ST_RD;
                end
                else if (bad_sum)
                begin
                    state_next = ST_ERR;
                end
                else if (stat.is_ack)
                begin
                    state_next = ST_ACK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.out_err = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_ACK:
            begin
                if (stat.out_free)
                begin
                    cmd.out_ack = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_WR;
            end
            ST_WR:
            begin
                if (stat.out_free)
                begin
                    cmd.out_byte = 1'b1;
                    state_next   = stat.rd_last ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            state_reg <= ST_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/uart_frame_deframer_checksum.sv @@
// ----------------------------------------------------------------------------
// uart_frame_deframer_checksum
// Hunts for a start code, collects type, length, payload and checksum bytes,
// replays a good frame byte by byte and reports checksum errors and
// acknowledge bytes.
// ----------------------------------------------------------------------------
// A byte is captured into a register and evaluated in the next cycle; a result
// is then loaded into the result register from the error, acknowledge or
// replay states once the result side is free. Replay reads each byte of a
// frame through the registered read port of the frame store and then outputs
// it, and the replay waits whenever the result side stalls.
// Reset is asynchronous and active low; the frame store needs no clearing pass.
// ----------------------------------------------------------------------------
module uart_frame_deframer_checksum import ufdc_pkg::*; #(
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input logic       clk,
    input logic       rst_n,
    ufdc_rx_if.sink   rx,
    ufdc_res_if.source res,
    ufdc_cfg_if.sink  cfg
);

    ufdc_cmd_t  cmd;
    ufdc_stat_t stat;

    assign cfg.ready = 1'b1;

    ufdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ufdc_dpath #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .rx_byte     (rx.rx_byte),
        .cfg_valid   (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .res_ready   (res.ready),
        .res_valid   (res.valid),
        .kind        (res.kind),
        .frame_data  (res.frame_data),
        .last        (res.last),
        .ack_seen    (res.ack_seen),
        .reply_valid (res.reply_valid),
        .reply_byte  (res.reply_byte)
    );

    // Only one byte is in work at a time.
    a_one_byte_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        rx.valid && rx.ready |=> !rx.ready)
        else $error("input taken while a byte is still being evaluated");

    a_ack_only_result: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.kind == KIND_ACK) |->
            res.ack_seen && res.last && !res.reply_valid)
        else $error("acknowledge result with wrong flags");

    a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.kind == KIND_ERR) |-> res.reply_valid && res.last)
        else $error("checksum error result without a reply");

    a_reply_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.reply_valid |-> res.last)
        else $error("reply requested on a result that is not the final one");

endmodule
